// ===== rtl/rwdm_pkg.sv =====
// Package for the radar word deframer: field positions, job record and back-end states.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps

package rwdm_pkg;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned WORD_W      = 64;
  localparam int unsigned WORD_BYTES  = 8;
  localparam int unsigned COUNT_W     = 4;

  localparam logic [7:0] WORD_HEADER  = 8'h80;
  localparam logic [3:0] TAIL_MASK    = 4'hF;

  localparam int unsigned SAMPLE_LSB  = 4;
  localparam int unsigned SAMPLE_W    = 25;
  localparam int unsigned BIN_LSB     = 29;
  localparam int unsigned BIN_W       = 10;
  localparam int unsigned CHANNEL_LSB = 39;

  localparam int unsigned MAG_W       = 25;
  // Each square is at most 2**48 and their sum at most 2**49, which fits in SUM_W bits.
  localparam int unsigned SUM_W       = 2 * SAMPLE_W;
  localparam int unsigned ROOT_STEPS  = SUM_W / 2;

  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 40;

  // One magnitude to compute: the bin and the two absolute sample values.
  typedef struct packed {
    logic [BIN_W-1:0]    bin;
    logic [SAMPLE_W-1:0] a_abs;
    logic [SAMPLE_W-1:0] b_abs;
  } job_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SQA,
    BK_SQB,
    BK_ADD,
    BK_ROOT,
    BK_DONE
  } back_state_t;

endpackage

// ===== rtl/rwdm_front.sv =====
// Front end: assembles bytes into words, keeps sync and the repeat check, pairs samples.
// Depends on rwdm_pkg; pushes one job_t into the queue for each completed pair.
`timescale 1ns / 1ps

module rwdm_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   byte_valid,
  output logic                   byte_ready,
  input  logic [7:0]             byte_data,
  input  logic                   queue_full,
  output logic                   push,
  output rwdm_pkg::job_t         push_job
);
  import rwdm_pkg::*;

  logic [WORD_W-1:0]   window;
  logic [COUNT_W-1:0]  count;
  logic                in_sync;
  logic                awaiting;
  logic [WORD_W-1:0]   prev_word;
  logic [SAMPLE_W-1:0] prev_sample;
  logic [BIN_W-1:0]    prev_bin;
  logic                prev_channel;

  logic [WORD_W-1:0]   window_next;
  logic [COUNT_W-1:0]  count_inc;
  logic                take;
  logic                word_ok;
  logic                repeat_hit;
  logic [SAMPLE_W-1:0] sample;
  logic [BIN_W-1:0]    bin;
  logic                channel;
  logic                pair;
  logic                accept;

  assign byte_ready  = !queue_full;
  assign accept      = byte_valid && byte_ready;
  assign window_next = {window[WORD_W-BYTE_W-1:0], byte_data};
  assign count_inc   = (count < COUNT_W'(WORD_BYTES)) ? count + 1'b1 : count;

  assign word_ok = (window_next[WORD_W-1 -: 8] == WORD_HEADER) &&
                   ((window_next[3:0] & TAIL_MASK) == 4'h0);
  // While hunting, a full window is a word only if it opens with the header
  // and closes with a zero byte.
  assign take = (count_inc == COUNT_W'(WORD_BYTES)) &&
                (in_sync || ((window_next[WORD_W-1 -: 8] == WORD_HEADER) &&
                             (window_next[7:0] == 8'h00)));

  assign sample     = window_next[SAMPLE_LSB +: SAMPLE_W];
  assign bin        = window_next[BIN_LSB +: BIN_W];
  assign channel    = window_next[CHANNEL_LSB];
  assign repeat_hit = word_ok && awaiting && (window_next == prev_word);
  assign pair       = repeat_hit && (bin == prev_bin) && (channel != prev_channel);

  assign push           = accept && take && pair;
  assign push_job.bin   = bin;
  assign push_job.a_abs = sample[SAMPLE_W-1] ? (~sample + 1'b1) : sample;
  assign push_job.b_abs = prev_sample[SAMPLE_W-1] ? (~prev_sample + 1'b1) : prev_sample;

  always_ff @(posedge clk) begin
    if (rst) begin
      window       <= '0;
      count        <= '0;
      in_sync      <= 1'b0;
      awaiting     <= 1'b0;
      prev_word    <= '0;
      prev_sample  <= '0;
      prev_bin     <= '0;
      prev_channel <= 1'b0;
    end else if (accept) begin
      window <= window_next;
      count  <= take ? '0 : count_inc;
      if (take) begin
        in_sync <= word_ok;
        if (!word_ok) begin
          awaiting <= 1'b0;
        end else begin
          prev_word <= window_next;
          if (!awaiting) begin
            awaiting <= 1'b1;
          end else if (repeat_hit) begin
            awaiting     <= 1'b0;
            prev_sample  <= sample;
            prev_bin     <= bin;
            prev_channel <= channel;
          end
        end
      end
    end
  end

endmodule

// ===== rtl/rwdm_queue.sv =====
// Two-entry job queue between the front end and the magnitude unit.
// Depends on rwdm_pkg for job_t.
`timescale 1ns / 1ps

module rwdm_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  rwdm_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output logic           valid,
  output rwdm_pkg::job_t pop_job
);
  import rwdm_pkg::*;

  job_t       entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign full    = (fill == 2'd2);
  assign valid   = (fill != 2'd0);
  assign pop_job = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

endmodule

// ===== rtl/rwdm_back.sv =====
// Back end: squares both samples, adds them and takes the floor square root two bits a step.
// Depends on rwdm_pkg; holds the result in an output register until it is taken.
`timescale 1ns / 1ps

module rwdm_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        job_valid,
  input  rwdm_pkg::job_t              job,
  output logic                        pop,
  output logic                        res_valid,
  input  logic                        res_ready,
  output logic [rwdm_pkg::BIN_W-1:0]  res_bin,
  output logic [rwdm_pkg::MAG_W-1:0]  res_mag
);
  import rwdm_pkg::*;

  back_state_t state;
  back_state_t state_next;

  job_t             cur;
  logic [SUM_W-1:0] acc;
  logic [SUM_W-1:0] prod;
  logic [SUM_W-1:0] rem;
  logic [SUM_W-1:0] root;
  logic [SUM_W-1:0] bitmask;
  logic [SUM_W-1:0] trial;
  logic             load;

  assign trial = root + bitmask;

  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: if (job_valid) state_next = BK_SQA;
      BK_SQA:  state_next = BK_SQB;
      BK_SQB:  state_next = BK_ADD;
      BK_ADD:  state_next = BK_ROOT;
      BK_ROOT: if (bitmask[0]) state_next = BK_DONE;
      BK_DONE: if (!res_valid || res_ready) state_next = BK_IDLE;
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    pop  = 1'b0;
    load = 1'b0;
    case (state)
      BK_IDLE: pop  = job_valid;
      BK_DONE: load = !res_valid || res_ready;
      default: begin
        pop  = 1'b0;
        load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      BK_IDLE: if (pop) cur <= job;
      BK_SQA:  acc  <= {{SAMPLE_W{1'b0}}, cur.a_abs} * {{SAMPLE_W{1'b0}}, cur.a_abs};
      BK_SQB:  prod <= {{SAMPLE_W{1'b0}}, cur.b_abs} * {{SAMPLE_W{1'b0}}, cur.b_abs};
      BK_ADD: begin
        rem     <= acc + prod;
        root    <= '0;
        bitmask <= {2'b01, {(SUM_W-2){1'b0}}};
      end
      BK_ROOT: begin
        if (rem >= trial) begin
          rem  <= rem - trial;
          root <= (root >> 1) + bitmask;
        end else begin
          root <= root >> 1;
        end
        bitmask <= bitmask >> 2;
      end
      BK_DONE: if (load) begin
        res_bin <= cur.bin;
        res_mag <= root[MAG_W-1:0];
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/radar_word_deframer_magnitude.sv =====
// Top level of the radar word deframer: byte stream in, bin and magnitude out.
// Depends on rwdm_pkg, rwdm_front, rwdm_queue and rwdm_back.
`timescale 1ns / 1ps

// Channel   Dir  Item                         tdata fields (low bit first)
// s_axis    in   one raw byte from the link   [7:0] stream_byte
// m_axis    out  one bin and its magnitude    [9:0] bin_index, [34:10] magnitude
//
// The front end takes one byte per cycle while the job queue is not full; it
// assembles 8-byte words, keeps word sync and the repeat check, and queues a
// job for every completed pair. The magnitude unit takes a job from the queue,
// forms the two squares and their sum, runs the two-bits-per-step square root
// and loads the output; it takes no new job until that result is loaded.
// s_tready falls only when the two-entry job queue is full, and the unit
// waits with a finished result while the output register is still held.
// Reset (rst, synchronous) returns to hunting with all history cleared.
module radar_word_deframer_magnitude (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] stream_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata    // [9:0] bin_index, [34:10] magnitude, [39:35] zero
);
  import rwdm_pkg::*;

  job_t             push_job;
  job_t             pop_job;
  logic             push;
  logic             pop;
  logic             queue_full;
  logic             queue_valid;
  logic [BIN_W-1:0] res_bin;
  logic [MAG_W-1:0] res_mag;

  rwdm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (s_tvalid),
    .byte_ready (s_tready),
    .byte_data  (s_tdata),
    .queue_full (queue_full),
    .push       (push),
    .push_job   (push_job)
  );

  rwdm_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (queue_full),
    .pop      (pop),
    .valid    (queue_valid),
    .pop_job  (pop_job)
  );

  rwdm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (queue_valid),
    .job       (pop_job),
    .pop       (pop),
    .res_valid (m_tvalid),
    .res_ready (m_tready),
    .res_bin   (res_bin),
    .res_mag   (res_mag)
  );

  // Bin in the low bits, magnitude above it, zero fill to whole bytes.
  assign m_tdata = {{(OUT_TDATA_W-BIN_W-MAG_W){1'b0}}, res_mag, res_bin};

endmodule
